/* sv/prk_pkg.sv */
// ----------------------------------------------------------------------------
// prk_pkg
// Shared constants, widths and structs of the permutation rank unit.
// ----------------------------------------------------------------------------
package prk_pkg;

  // Permutation length
  localparam int NUM_ELEMENTS = 16;

  localparam int ELEM_W = 5;                          // element_value field
  localparam int RANK_W = 45;                         // rank_value field
  localparam int CNT_W  = $clog2(NUM_ELEMENTS);       // count of smaller later elements
  localparam int ITEM_W = $clog2(NUM_ELEMENTS + 1);   // element counter, 0..N
  localparam int IDX_W  = $clog2(NUM_ELEMENTS);       // position / value index

  // FSM codes of the top level
  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_DRAIN  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Contents of one cell of the chain
  typedef struct packed {
    logic              vld;
    logic [ELEM_W-1:0] elem;
    logic [CNT_W-1:0]  cnt;
  } cell_data_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic              load;    // shift in with compare against value
    logic              drain;   // shift counts toward cell 0
    logic [ELEM_W-1:0] value;   // element being loaded
  } cell_ctl_t;

  // Control of the rank accumulator
  typedef struct packed {
    logic              step;    // take one count
    logic              first;   // first count: start from zero
    logic [ITEM_W-1:0] mult;    // radix of this digit
  } acc_ctl_t;

endpackage

/* sv/prk_if.sv */
// ----------------------------------------------------------------------------
// prk_if
// Valid/ready channels of the permutation rank unit.
// ----------------------------------------------------------------------------
interface prk_in_if;
  logic                      valid;
  logic                      ready;
  logic [prk_pkg::ELEM_W-1:0] element_value;
  logic                      last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface prk_out_if;
  logic                      valid;
  logic                      ready;
  logic [prk_pkg::RANK_W-1:0] rank_value;
  logic                      bad_input;

  modport source (output valid, output rank_value, output bad_input, input ready);
  modport sink   (input valid, input rank_value, input bad_input, output ready);
endinterface

/* sv/prk_cell.sv */
// ----------------------------------------------------------------------------
// prk_cell
// One position of the permutation: element, count of smaller later elements.
// ----------------------------------------------------------------------------
module prk_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  prk_pkg::cell_ctl_t  ctl,
  input  prk_pkg::cell_data_t up,
  output prk_pkg::cell_data_t own
);

  prk_pkg::cell_data_t own_r;
  prk_pkg::cell_data_t own_nxt;
  logic                smaller;

  // New element is smaller than the one moving into this cell
  assign smaller = up.vld && (ctl.value < up.elem);

  always_comb begin
    own_nxt = own_r;
    if (ctl.load) begin
      own_nxt.vld  = up.vld;
      own_nxt.elem = up.elem;
      own_nxt.cnt  = up.cnt + prk_pkg::CNT_W'(smaller);
    end else if (ctl.drain) begin
      own_nxt = up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r.vld  <= 1'b0;
      own_r.elem <= '0;
      own_r.cnt  <= '0;
    end else begin
      own_r <= own_nxt;
    end
  end

  assign own = own_r;

endmodule

/* sv/prk_accum.sv */
// ----------------------------------------------------------------------------
// prk_accum
// Mixed-radix accumulator: folds the counts into the rank one digit a cycle.
// ----------------------------------------------------------------------------
module prk_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  prk_pkg::acc_ctl_t          ctl,
  input  logic [prk_pkg::CNT_W-1:0]  cnt,
  output logic [prk_pkg::RANK_W-1:0] acc
);

  logic [prk_pkg::RANK_W-1:0]                 acc_r;
  logic [prk_pkg::RANK_W-1:0]                 acc_nxt;
  logic [prk_pkg::RANK_W+prk_pkg::ITEM_W-1:0] prod;

  assign prod = acc_r * ctl.mult;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.step) begin
      if (ctl.first) begin
        acc_nxt = prk_pkg::RANK_W'(cnt);
      end else begin
        // rank modulo 2^RANK_W
        acc_nxt = prod[prk_pkg::RANK_W-1:0] + prk_pkg::RANK_W'(cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* sv/permutation_rank_unit.sv */
// ----------------------------------------------------------------------------
// permutation_rank_unit
// Lexicographic rank (Lehmer code) of a permutation of 1..N.
// ----------------------------------------------------------------------------
// Send the N elements of a permutation, one transfer each, with last_element
// set on the final one. Each element enters the tail of a chain of N cells,
// every occupied cell counts whether the new element is smaller than its own,
// and all cells move one place toward cell 0. After the marked element the
// chain drains, feeding one count per cycle from cell 0 into the single
// multiply-add accumulator (rank = rank * (N - k) + c_k), and the finish
// state places the result in the output register once that register is free.
// The input stalls during drain and finish, so a new permutation is taken
// only after the last one is through. A result waiting at the output does not
// block loading of the next permutation. An element of 0 or above N, a
// repeated value, an element beyond N, or a marked element that closes fewer
// than N elements gives bad_input = 1 with rank 0.
// ----------------------------------------------------------------------------
module permutation_rank_unit (
  input  logic      clk,
  input  logic      rst_n,
  prk_in_if.sink    in_ch,
  prk_out_if.source out_ch
);

  localparam int N = prk_pkg::NUM_ELEMENTS;

  // FSM and bookkeeping
  logic [1:0]                 state_r, state_nxt;
  logic [prk_pkg::ITEM_W-1:0] items_r, items_nxt;
  logic [N-1:0]               seen_r, seen_nxt;
  logic                       err_r, err_nxt;
  logic                       fin_err_r, fin_err_nxt;
  logic [prk_pkg::IDX_W-1:0]  step_r, step_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic [prk_pkg::RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic                       out_bad_r, out_bad_nxt;

  // Element checks
  logic                       in_fire;
  logic                       over_cnt;
  logic                       range_bad;
  logic                       dup;
  logic                       store;
  logic                       err_now;
  logic [prk_pkg::IDX_W-1:0]  val_idx;
  logic [prk_pkg::ITEM_W-1:0] items_inc;

  // Chain and accumulator
  prk_pkg::cell_ctl_t         cell_ctl;
  prk_pkg::cell_data_t        link [N+1];
  prk_pkg::acc_ctl_t          acc_ctl;
  logic [prk_pkg::RANK_W-1:0] acc;
  logic                       out_free;

  assign in_ch.ready = (state_r == prk_pkg::ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign over_cnt  = (items_r >= prk_pkg::ITEM_W'(N));
  assign range_bad = (in_ch.element_value == '0) ||
                     (in_ch.element_value > prk_pkg::ELEM_W'(N));
  assign val_idx   = prk_pkg::IDX_W'(in_ch.element_value - prk_pkg::ELEM_W'(1));
  assign store     = !over_cnt && !range_bad;
  assign dup       = store && seen_r[val_idx];
  assign items_inc = over_cnt ? items_r : items_r + prk_pkg::ITEM_W'(1);
  assign err_now   = err_r || over_cnt || range_bad || dup;

  // Broadcast to cells: shift in a good element, or drain during the rank pass
  always_comb begin
    cell_ctl.load  = in_fire && store;
    cell_ctl.drain = (state_r == prk_pkg::ST_DRAIN);
    cell_ctl.value = in_ch.element_value;
  end

  // Tail feed: the new element on load, empty on drain
  always_comb begin
    link[N].vld  = cell_ctl.load;
    link[N].elem = cell_ctl.load ? in_ch.element_value : '0;
    link[N].cnt  = '0;
  end

  for (genvar p = 0; p < N; p++) begin : g_cell
    prk_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl),
      .up    (link[p+1]),
      .own   (link[p])
    );
  end

  // Digit k weighs by (N-1-k)!, folded in as radix N-k
  always_comb begin
    acc_ctl.step  = (state_r == prk_pkg::ST_DRAIN);
    acc_ctl.first = (step_r == '0);
    acc_ctl.mult  = prk_pkg::ITEM_W'(N) - prk_pkg::ITEM_W'(step_r);
  end

  prk_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .cnt   (link[0].cnt),
    .acc   (acc)
  );

  always_comb begin
    state_nxt     = state_r;
    items_nxt     = items_r;
    seen_nxt      = seen_r;
    err_nxt       = err_r;
    fin_err_nxt   = fin_err_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rank_nxt  = out_rank_r;
    out_bad_nxt   = out_bad_r;
    unique case (state_r)
      prk_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (in_ch.last_element) begin
            // close this permutation, clear bookkeeping for the next one
            fin_err_nxt = err_now || (items_inc != prk_pkg::ITEM_W'(N));
            items_nxt   = '0;
            seen_nxt    = '0;
            err_nxt     = 1'b0;
            step_nxt    = '0;
            state_nxt   = prk_pkg::ST_DRAIN;
          end else begin
            items_nxt = items_inc;
            err_nxt   = err_now;
            if (store) begin
              seen_nxt = seen_r | (N'(1) << val_idx);
            end
          end
        end
      end
      prk_pkg::ST_DRAIN: begin
        step_nxt = step_r + prk_pkg::IDX_W'(1);
        if (step_r == prk_pkg::IDX_W'(N - 1)) begin
          state_nxt = prk_pkg::ST_FINISH;
        end
      end
      prk_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rank_nxt  = fin_err_r ? '0 : acc;
          out_bad_nxt   = fin_err_r;
          state_nxt     = prk_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = prk_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prk_pkg::ST_LOAD;
      items_r     <= '0;
      seen_r      <= '0;
      err_r       <= 1'b0;
      fin_err_r   <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      items_r     <= items_nxt;
      seen_r      <= seen_nxt;
      err_r       <= err_nxt;
      fin_err_r   <= fin_err_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    out_rank_r <= out_rank_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.rank_value = out_rank_r;
  assign out_ch.bad_input  = out_bad_r;

`ifndef SYNTHESIS
  // Drain empties the chain before the result is formed
  a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prk_pkg::ST_FINISH) |-> !link[0].vld)
    else $error("chain not empty after drain");

  // A failed permutation reports rank zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_input) |-> (out_ch.rank_value == '0))
    else $error("nonzero rank with bad_input");

  // The marked element starts the drain with cleared bookkeeping
  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_element) |=>
      (state_r == prk_pkg::ST_DRAIN) && (items_r == '0) && (step_r == '0))
    else $error("drain not started after last element");

  // Element counter saturates at N
  a_items_cap: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= prk_pkg::ITEM_W'(N))
    else $error("element counter beyond N");
`endif

endmodule
